// ===== hw/rtl/lwst_pkg.sv =====
package lwst_pkg;

  localparam int DATA_W         = 32;
  localparam int WIDE_W         = 64;
  localparam int NAME_MAX_BYTES = 16;
  localparam int OUT_IDX_W      = 6;
  localparam int INTERVAL_W     = 16;

  localparam logic [DATA_W-1:0]     CNT_MAX        = '1;
  localparam logic [DATA_W-1:0]     UTIL_SAT       = '1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL_MEAN,
    S_DIV_MEAN_GO,
    S_DIV_MEAN,
    S_MUL_UTIL,
    S_DIV_UTIL_GO,
    S_DIV_UTIL
  } lwst_state_t;

  // data carried along the cell chain during a search
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] mean;
  } lwst_hit_t;

  // write-back request broadcast to all cells
  typedef struct packed {
    logic              wen;
    logic              open;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] mean;
  } lwst_wr_t;

endpackage

// ===== hw/rtl/lwst_cell.sv =====
module lwst_cell #(
  parameter int KEY_W    = 160,
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [KEY_W-1:0]   key,
  input  logic               scan_in,
  input  lwst_pkg::lwst_hit_t hit_in,
  input  logic [IDX_W-1:0]   idx_in,
  output logic               scan_out,
  output lwst_pkg::lwst_hit_t hit_out,
  output logic [IDX_W-1:0]   idx_out,
  input  lwst_pkg::lwst_wr_t wr,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [KEY_W-1:0]   wr_key
);
  import lwst_pkg::*;

  logic              valid;
  logic [KEY_W-1:0]  slot_key;
  logic [DATA_W-1:0] slot_count;
  logic [DATA_W-1:0] slot_mean;
  logic              match;
  logic              take;
  logic              sel;

  assign match = valid && (slot_key == key);
  assign take  = scan_in && !hit_in.found && match;
  assign sel   = wr.wen && (wr_idx == IDX_W'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      scan_out <= 1'b0;
    end else begin
      scan_out <= scan_in;
      if (sel && wr.open) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit_out <= '{found: 1'b1, count: slot_count, mean: slot_mean};
      idx_out <= IDX_W'(CELL_IDX);
    end else begin
      hit_out <= hit_in;
      idx_out <= idx_in;
    end
    if (sel) begin
      slot_count <= wr.count;
      slot_mean  <= wr.mean;
      if (wr.open) begin
        slot_key <= wr_key;
      end
    end
  end

endmodule

// ===== hw/rtl/lwst_div.sv =====
module lwst_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lwst_pkg::WIDE_W-1:0] dividend,
  input  logic [lwst_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [lwst_pkg::WIDE_W-1:0] quotient
);
  import lwst_pkg::*;

  localparam int STEP_W = $clog2(WIDE_W);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [WIDE_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_nx;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, quo[WIDE_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    rem_nx = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && (step == STEP_W'(WIDE_W - 1))) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (active) begin
      step <= step + STEP_W'(1);
      rem  <= rem_nx[DATA_W-1:0];
      quo  <= {quo[WIDE_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== hw/rtl/lock_wait_stats_table.sv =====
// lock wait statistics table: one request at a time, one result per request
// a result follows the search token walking the cell chain and two bit-serial divisions,
// one for the mean and one for the utilization
// a zero interval skips the second division; a miss on a full table answers after the scan alone
// throughput: a new start is taken in the cycle the done strobe shows; results cannot stall
// synchronous reset clears all slots, the fill level, the state and sets the interval to 5
module lock_wait_stats_table #(
  parameter int ENTRIES    = 64,
  parameter int NAME_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [63:0]                     name_low,
  input  logic [63:0]                     name_high,
  input  logic [lwst_pkg::DATA_W-1:0]     resource_addr,
  input  logic [lwst_pkg::DATA_W-1:0]     wait_sample,
  input  logic                            cfg_we,
  input  logic [lwst_pkg::INTERVAL_W-1:0] cfg_wdata,
  output logic                            done,
  output logic [lwst_pkg::OUT_IDX_W-1:0]  entry_index,
  output logic [lwst_pkg::DATA_W-1:0]     hit_count,
  output logic [lwst_pkg::DATA_W-1:0]     mean_wait,
  output logic [lwst_pkg::DATA_W-1:0]     utilization,
  output logic                            new_entry,
  output logic                            table_full
);
  import lwst_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int KEY_W  = NAME_W + DATA_W;

  lwst_state_t state, state_next;

  logic [INTERVAL_W-1:0] interval_seconds;
  logic [FILL_W-1:0]     fill_level;
  logic                  scan_go;
  logic [KEY_W-1:0]      key_q;
  logic [DATA_W-1:0]     sample_q;
  logic [IDX_W-1:0]      slot_q;
  logic                  opened_q;
  logic [DATA_W-1:0]     n_q;
  logic [DATA_W-1:0]     mean_old_q;
  logic [WIDE_W-1:0]     prod_q;
  logic [DATA_W-1:0]     mean_q;

  logic [8*NAME_MAX_BYTES-1:0] raw_name;
  logic [8*NAME_MAX_BYTES-1:0] canon_name;
  logic                        name_ended;
  logic [KEY_W-1:0]            key_in;

  logic      accept;
  logic      scan_end;
  lwst_hit_t scan_hit;
  logic [IDX_W-1:0] scan_idx;
  logic      table_is_full;
  logic [DATA_W-1:0] old_count;

  logic              div_start;
  logic [WIDE_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic              div_done;
  logic [WIDE_W-1:0] div_quotient;

  lwst_wr_t wr;

  logic [IDX_W+OUT_IDX_W-1:0] slot_ext;

  // chain wiring
  logic              chain_scan [ENTRIES+1];
  lwst_hit_t         chain_hit  [ENTRIES+1];
  logic [IDX_W-1:0]  chain_idx  [ENTRIES+1];

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // name ends at the first zero byte or at NAME_BYTES
  always_comb begin
    raw_name   = {name_high, name_low};
    canon_name = raw_name;
    name_ended = 1'b0;
    for (int b = 0; b < NAME_MAX_BYTES; b++) begin
      if ((b >= NAME_BYTES) || (raw_name[8*b +: 8] == 8'd0)) begin
        name_ended = 1'b1;
      end
      if (name_ended) begin
        canon_name[8*b +: 8] = 8'd0;
      end
    end
    key_in = {canon_name[NAME_W-1:0], resource_addr};
  end

  assign chain_scan[0] = scan_go;
  assign chain_hit[0]  = '0;
  assign chain_idx[0]  = '0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    lwst_cell #(
      .KEY_W    (KEY_W),
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (key_q),
      .scan_in  (chain_scan[k]),
      .hit_in   (chain_hit[k]),
      .idx_in   (chain_idx[k]),
      .scan_out (chain_scan[k+1]),
      .hit_out  (chain_hit[k+1]),
      .idx_out  (chain_idx[k+1]),
      .wr       (wr),
      .wr_idx   (slot_q),
      .wr_key   (key_q)
    );
  end

  assign scan_end      = chain_scan[ENTRIES];
  assign scan_hit      = chain_hit[ENTRIES];
  assign scan_idx      = chain_idx[ENTRIES];
  assign table_is_full = (fill_level == FILL_W'(ENTRIES));
  // a miss starts from count 0, so the update formula yields count 1, mean = sample
  assign old_count     = scan_hit.found ? scan_hit.count : '0;

  lwst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = prod_q + WIDE_W'(sample_q);
    div_divisor  = n_q;
    wr           = '{wen: 1'b0, open: opened_q, count: n_q, mean: div_quotient[DATA_W-1:0]};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = (!scan_hit.found && table_is_full) ? S_IDLE : S_MUL_MEAN;
        end
      end
      S_MUL_MEAN: begin
        state_next = S_DIV_MEAN_GO;
      end
      S_DIV_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = S_DIV_MEAN;
      end
      S_DIV_MEAN: begin
        if (div_done) begin
          wr.wen     = 1'b1;
          state_next = S_MUL_UTIL;
        end
      end
      S_MUL_UTIL: begin
        state_next = S_DIV_UTIL_GO;
      end
      S_DIV_UTIL_GO: begin
        div_dividend = prod_q;
        div_divisor  = DATA_W'(interval_seconds);
        if (interval_seconds == '0) begin
          state_next = S_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV_UTIL;
        end
      end
      S_DIV_UTIL: begin
        if (div_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_seconds <= INTERVAL_RESET;
      fill_level       <= '0;
      scan_go          <= 1'b0;
      done             <= 1'b0;
    end else begin
      scan_go <= accept;
      done    <= 1'b0;
      if (cfg_we) begin
        interval_seconds <= cfg_wdata;
      end
      if (state == S_SCAN && scan_end && !scan_hit.found && table_is_full) begin
        done <= 1'b1;
      end
      if (state == S_DIV_MEAN && div_done && opened_q) begin
        fill_level <= fill_level + FILL_W'(1);
      end
      if (state == S_DIV_UTIL_GO && interval_seconds == '0) begin
        done <= 1'b1;
      end
      if (state == S_DIV_UTIL && div_done) begin
        done <= 1'b1;
      end
    end
  end

  assign slot_ext = (IDX_W + OUT_IDX_W)'(slot_q);

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_q    <= key_in;
          sample_q <= wait_sample;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          slot_q     <= scan_hit.found ? scan_idx : fill_level[IDX_W-1:0];
          opened_q   <= !scan_hit.found;
          mean_old_q <= scan_hit.found ? scan_hit.mean : '0;
          n_q        <= (old_count == CNT_MAX) ? CNT_MAX : old_count + DATA_W'(1);
          if (!scan_hit.found && table_is_full) begin
            entry_index <= '0;
            hit_count   <= '0;
            mean_wait   <= '0;
            utilization <= '0;
            new_entry   <= 1'b0;
            table_full  <= 1'b1;
          end
        end
      end
      S_MUL_MEAN: begin
        prod_q <= WIDE_W'(mean_old_q) * WIDE_W'(n_q - DATA_W'(1));
      end
      S_DIV_MEAN: begin
        if (div_done) begin
          mean_q <= div_quotient[DATA_W-1:0];
        end
      end
      S_MUL_UTIL: begin
        prod_q <= WIDE_W'(mean_q) * WIDE_W'(n_q);
      end
      S_DIV_UTIL_GO: begin
        entry_index <= slot_ext[OUT_IDX_W-1:0];
        hit_count   <= n_q;
        mean_wait   <= mean_q;
        new_entry   <= opened_q;
        table_full  <= 1'b0;
        utilization <= UTIL_SAT;
      end
      S_DIV_UTIL: begin
        if (div_done) begin
          utilization <= (div_quotient[WIDE_W-1:DATA_W] != '0) ? UTIL_SAT
                                                               : div_quotient[DATA_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
